[rtl/core/mchull_pkg.sv]
package mchull_pkg;

	// Sequencer states, one-hot
	typedef enum logic [15:0] {
		ST_LOAD   = 16'b0000000000000001,
		ST_SORT_K = 16'b0000000000000010,
		ST_SORT_L = 16'b0000000000000100,
		ST_SORT_R = 16'b0000000000001000,
		ST_SORT_C = 16'b0000000000010000,
		ST_HULL   = 16'b0000000000100000,
		ST_RD_O   = 16'b0000000001000000,
		ST_RD_A   = 16'b0000000010000000,
		ST_RD_B   = 16'b0000000100000000,
		ST_RD_C   = 16'b0000001000000000,
		ST_MUL    = 16'b0000010000000000,
		ST_DEC    = 16'b0000100000000000,
		ST_EMIT_S = 16'b0001000000000000,
		ST_EMIT_R = 16'b0010000000000000,
		ST_EMIT_W = 16'b0100000000000000,
		ST_EMIT_V = 16'b1000000000000000
	} mch_state_t;

	// Control from sequencer into the turn unit
	typedef struct packed {
		logic load_o;
		logic load_a;
		logic load_b;
		logic mult;
	} mch_turn_ctl_t;

endpackage

[rtl/core/mchull_turn.sv]
// Cross product of (a - o) and (b - o): load/subtract, then multiply.
module mchull_turn #(
	parameter int COORD_BITS = 16
) (
	input  logic                          clk,
	input  mchull_pkg::mch_turn_ctl_t     ctl,
	input  logic signed [COORD_BITS-1:0]  px,
	input  logic signed [COORD_BITS-1:0]  py,
	output logic                          nonpos
);
	import mchull_pkg::*;

	localparam int DW = COORD_BITS + 1;
	localparam int PW = 2 * DW + 1;

	logic signed [COORD_BITS-1:0] ox_q, oy_q;
	logic signed [DW-1:0]         ax_q, ay_q, bx_q, by_q;
	logic signed [PW-1:0]         p1_q, p2_q;

	always_ff @(posedge clk) begin
		if (ctl.load_o) begin
			ox_q <= px;
			oy_q <= py;
		end
		if (ctl.load_a) begin
			ax_q <= DW'(px) - DW'(ox_q);
			ay_q <= DW'(py) - DW'(oy_q);
		end
		if (ctl.load_b) begin
			bx_q <= DW'(px) - DW'(ox_q);
			by_q <= DW'(py) - DW'(oy_q);
		end
		if (ctl.mult) begin
			p1_q <= PW'(ax_q * by_q);
			p2_q <= PW'(ay_q * bx_q);
		end
	end

	assign nonpos = (p1_q <= p2_q);
endmodule

[rtl/core/monotone_chain_convex_hull_unit.sv]
// Andrew monotone-chain convex hull. Requests carry one point each. A request
// with last_point starts an insertion sort of the stored points: each key is
// read, then the entry below it, then compared and written; each shift reads
// the next entry below and compares again, and a final key check closes the
// sort. The lower and upper hull passes follow; each cross-product test makes
// two hull-stack reads and three point-memory reads through single registered
// ports, then subtract, multiply and decide in one shared unit. Each vertex
// is emitted through a stack read, a point read and an output register, and
// is held while the output stalls. The input stalls from the last point until
// the final vertex is taken. Enabled points beyond MAX_POINTS are dropped and
// flag overflow on every vertex of that set.
module monotone_chain_convex_hull_unit #(
	parameter int MAX_POINTS = 64,
	parameter int COORD_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] point_x,
	input  logic [15:0] point_y,
	input  logic        enabled,
	input  logic        last_point,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] vertex_x,
	output logic [15:0] vertex_y,
	output logic [5:0]  vertex_number,
	output logic        last_vertex,
	output logic        overflow
);
	import mchull_pkg::*;

	localparam int CB = (COORD_BITS < 16) ? COORD_BITS : 16;
	localparam int AW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int SD = 2 * MAX_POINTS + 1;
	localparam int SW = $clog2(SD + 1);
	localparam int SA = $clog2(SD);

	mch_state_t state_q;

	// point memory: one port, registered read
	logic signed [CB-1:0] mem_x [MAX_POINTS];
	logic signed [CB-1:0] mem_y [MAX_POINTS];
	logic [AW-1:0]        addr;
	logic                 we;
	logic signed [CB-1:0] wx, wy, rx_q, ry_q;

	// hull stack of point indices: one write, one registered read
	logic [AW-1:0] hstack [SD];
	logic [SA-1:0] hs_addr;
	logic [AW-1:0] hs_rd_q;
	logic          hs_push;

	logic [SW-1:0] sdep_q;
	logic [CW-1:0] cnt_q;
	logic          ovf_q;

	logic [CW-1:0] i_q, j_q;
	logic signed [CB-1:0] kx_q, ky_q;
	logic          upper_q;
	logic [SW-1:0] floor_q;
	logic [5:0]    k_q;
	logic [SW-1:0] m_q;
	logic          nonpos;
	mch_turn_ctl_t tctl;

	logic          accept;
	logic [AW-1:0] cur_idx;
	logic          can_pop;
	logic          lower_done;
	logic          upper_done;
	logic          key_gt;

	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != ST_LOAD);

	always_ff @(posedge clk) begin
		if (we) begin
			mem_x[addr] <= wx;
			mem_y[addr] <= wy;
		end
		rx_q <= mem_x[addr];
		ry_q <= mem_y[addr];
	end

	always_ff @(posedge clk) begin
		if (hs_push)
			hstack[SA'(sdep_q)] <= cur_idx;
		hs_rd_q <= hstack[hs_addr];
	end

	// index of the current hull point being considered
	assign cur_idx = upper_q ? AW'(i_q - CW'(1)) : AW'(i_q);

	// hull condition before a test, and the ends of both passes
	assign can_pop    = upper_q ? (sdep_q >= floor_q) : (sdep_q >= SW'(2));
	assign lower_done = !upper_q && (i_q == cnt_q);
	assign upper_done = upper_q && (i_q == '0);

	// shift the entry below the hole while it sorts after the key
	assign key_gt = (j_q != '0) && (rx_q > kx_q || (rx_q == kx_q && ry_q > ky_q));

	// push when no test is due, or when the test keeps the top entry
	assign hs_push = ((state_q == ST_HULL) && !lower_done && !upper_done && !can_pop) ||
	                 ((state_q == ST_DEC) && !nonpos);

	// address and write data selection
	always_comb begin
		we = 1'b0;
		addr = '0;
		wx = kx_q;
		wy = ky_q;
		hs_addr = '0;
		unique case (state_q)
			ST_LOAD: begin
				we = accept && enabled && (cnt_q < CW'(MAX_POINTS));
				addr = AW'(cnt_q);
				wx = CB'(point_x);
				wy = CB'(point_y);
			end
			ST_SORT_K: addr = AW'(i_q);
			ST_SORT_L: addr = AW'(i_q - CW'(1));
			ST_SORT_R: addr = (j_q == '0) ? '0 : AW'(j_q - CW'(1));
			ST_SORT_C: begin
				addr = AW'(j_q);
				we = 1'b1;
				if (key_gt) begin
					wx = rx_q;
					wy = ry_q;
				end
			end
			ST_HULL: if (can_pop) hs_addr = SA'(sdep_q - SW'(2));
			ST_RD_O: begin
				addr = hs_rd_q;
				hs_addr = SA'(sdep_q - SW'(1));
			end
			ST_RD_A:   addr = hs_rd_q;
			ST_RD_B:   addr = cur_idx;
			ST_EMIT_S: hs_addr = SA'(k_q);
			ST_EMIT_R: addr = (cnt_q < CW'(3)) ? AW'(k_q) : hs_rd_q;
			default: ;
		endcase
	end

	always_comb begin
		tctl = '0;
		tctl.load_o = (state_q == ST_RD_A);
		tctl.load_a = (state_q == ST_RD_B);
		tctl.load_b = (state_q == ST_RD_C);
		tctl.mult   = (state_q == ST_MUL);
	end

	mchull_turn #(.COORD_BITS(CB)) u_turn (
		.clk(clk), .ctl(tctl), .px(rx_q), .py(ry_q), .nonpos(nonpos)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cnt_q <= '0;
			ovf_q <= 1'b0;
			sdep_q <= '0;
			out_valid <= 1'b0;
			i_q <= '0;
			j_q <= '0;
			kx_q <= '0;
			ky_q <= '0;
			upper_q <= 1'b0;
			floor_q <= '0;
			k_q <= '0;
			m_q <= '0;
			vertex_x <= '0;
			vertex_y <= '0;
			vertex_number <= '0;
			last_vertex <= 1'b0;
			overflow <= 1'b0;
		end else begin
			unique case (state_q)
				ST_LOAD: if (accept) begin
					if (enabled && cnt_q < CW'(MAX_POINTS)) cnt_q <= cnt_q + CW'(1);
					if (enabled && cnt_q == CW'(MAX_POINTS)) ovf_q <= 1'b1;
					if (last_point) begin
						// sort starts with the key at index 1
						i_q <= CW'(1);
						state_q <= ST_SORT_K;
					end
				end
				ST_SORT_K: begin
					if (i_q < cnt_q) begin
						state_q <= ST_SORT_L;
					end else begin
						sdep_q <= '0;
						i_q <= '0;
						upper_q <= 1'b0;
						k_q <= '0;
						if (cnt_q < CW'(3)) begin
							// too few points: emit the sorted set as it is
							m_q <= SW'(cnt_q);
							if (cnt_q == '0) begin
								ovf_q <= 1'b0;
								state_q <= ST_LOAD;
							end else begin
								state_q <= ST_EMIT_S;
							end
						end else begin
							state_q <= ST_HULL;
						end
					end
				end
				ST_SORT_L: begin
					// hold the key; the entry below it is being read
					kx_q <= rx_q;
					ky_q <= ry_q;
					j_q <= i_q;
					state_q <= ST_SORT_C;
				end
				ST_SORT_R: state_q <= ST_SORT_C;
				ST_SORT_C: begin
					if (key_gt) begin
						j_q <= j_q - CW'(1);
						state_q <= ST_SORT_R;
					end else begin
						i_q <= i_q + CW'(1);
						state_q <= ST_SORT_K;
					end
				end
				ST_HULL: begin
					if (lower_done) begin
						upper_q <= 1'b1;
						floor_q <= sdep_q + SW'(1);
						i_q <= cnt_q - CW'(1);
					end else if (upper_done) begin
						// drop the closing repeat of the first vertex
						m_q <= sdep_q - SW'(1);
						k_q <= '0;
						state_q <= ST_EMIT_S;
					end else if (can_pop) begin
						state_q <= ST_RD_O;
					end else begin
						sdep_q <= sdep_q + SW'(1);
						i_q <= upper_q ? i_q - CW'(1) : i_q + CW'(1);
					end
				end
				ST_RD_O: state_q <= ST_RD_A;
				ST_RD_A: state_q <= ST_RD_B;
				ST_RD_B: state_q <= ST_RD_C;
				ST_RD_C: state_q <= ST_MUL;
				ST_MUL:  state_q <= ST_DEC;
				ST_DEC: begin
					if (nonpos) begin
						sdep_q <= sdep_q - SW'(1);
					end else begin
						sdep_q <= sdep_q + SW'(1);
						i_q <= upper_q ? i_q - CW'(1) : i_q + CW'(1);
					end
					state_q <= ST_HULL;
				end
				ST_EMIT_S: state_q <= ST_EMIT_R;
				ST_EMIT_R: state_q <= ST_EMIT_W;
				ST_EMIT_W: begin
					vertex_x <= 16'(rx_q);
					vertex_y <= 16'(ry_q);
					vertex_number <= k_q;
					last_vertex <= (SW'(k_q) + SW'(1) == m_q);
					overflow <= ovf_q;
					out_valid <= 1'b1;
					state_q <= ST_EMIT_V;
				end
				ST_EMIT_V: if (!out_stall) begin
					out_valid <= 1'b0;
					if (SW'(k_q) + SW'(1) == m_q) begin
						cnt_q <= '0;
						ovf_q <= 1'b0;
						state_q <= ST_LOAD;
					end else begin
						k_q <= k_q + 6'd1;
						state_q <= ST_EMIT_S;
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> state_q == ST_EMIT_V) else $error("out_valid outside emit");
	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input open during emission");
	a_cnt_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_POINTS)) else $error("point count beyond capacity");
	a_stack_cap: assert property (@(posedge clk) disable iff (!arst_n)
		sdep_q <= SW'(SD)) else $error("stack overflow");
endmodule
